// ===== hdl/crcwu_pkg.sv =====
// crcwu_pkg: widths, register indexes and reset values for the crc32 word update unit
// no dependencies; used by the channel interfaces and by crc32_word_update_unit
package crcwu_pkg;

  localparam int unsigned CRC_W       = 32;
  localparam int unsigned COUNT_W     = 3;
  localparam int unsigned COL_IDX_W   = 5;
  localparam int unsigned CFG_INDEX_W = 2;

  typedef logic [CRC_W-1:0]       crc_word_t;
  typedef logic [COUNT_W-1:0]     byte_count_t;
  typedef logic [COL_IDX_W-1:0]   col_idx_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  // configuration register indexes
  localparam cfg_index_t REG_POLYNOMIAL    = 2'd0;
  localparam cfg_index_t REG_INITIAL_VALUE = 2'd1;

  localparam crc_word_t POLY_RESET     = 32'h04C1_1DB7;
  localparam crc_word_t INIT_RESET     = 32'h0000_0000;
  localparam crc_word_t CRC_ALL_ONES   = 32'hFFFF_FFFF;
  localparam col_idx_t  COL_LAST       = 5'd31;

endpackage

// ===== hdl/crcwu_channels.sv =====
// crcwu channel interfaces: input items, result items and configuration writes
// depends on crcwu_pkg
interface crcwu_in_if import crcwu_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        start_of_message;
  crc_word_t   data_word;
  byte_count_t byte_count;

  modport source (output valid, start_of_message, data_word, byte_count, input ready);
  modport sink   (input valid, start_of_message, data_word, byte_count, output ready);
endinterface

interface crcwu_out_if import crcwu_pkg::*; ();
  logic      valid;
  logic      ready;
  crc_word_t crc_value;

  modport source (output valid, crc_value, input ready);
  modport sink   (input valid, crc_value, output ready);
endinterface

interface crcwu_cfg_if import crcwu_pkg::*; ();
  logic       valid;
  logic       ready;
  cfg_index_t index;
  crc_word_t  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/crc32_word_update_unit.sv =====
// an accepted item passes the input register, then the result register; a stalled output holds both
// throughput: one 32-bit item per cycle while the output is not stalled and no build runs;
// the remainder register feeds back through a 32-column xor tree, columns x^(32+j) mod poly
// precomputed per polynomial; reset (sync, active low) and every polynomial write start a column
// build of all 32 columns, one column per cycle, during which no item is accepted;
// config writes always taken; depends on crcwu_pkg and crcwu_channels
module crc32_word_update_unit import crcwu_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  crcwu_in_if.sink      in_chan,
  crcwu_out_if.source   out_chan,
  crcwu_cfg_if.sink     cfg_chan
);

  crc_word_t   poly_r;
  crc_word_t   init_r;
  crc_word_t   rem_r;
  crc_word_t   rem_nxt;

  // column build sequencer
  crc_word_t   col_r [CRC_W];
  crc_word_t   work_r;
  crc_word_t   work_nxt;
  col_idx_t    build_cnt_r;
  logic        build_busy_r;

  // input register
  logic        s1_valid_r;
  logic        s1_sop_r;
  crc_word_t   s1_word_r;
  byte_count_t s1_cnt_r;

  // result register
  logic        out_valid_r;
  crc_word_t   crc_r;

  logic        in_fire;
  logic        advance;
  logic        poly_wr;
  logic        init_wr;
  crc_word_t   rem_base;
  crc_word_t   mix;
  crc_word_t   top_bits;
  crc_word_t   shifted;
  crc_word_t   folded;

  assign poly_wr = cfg_chan.valid && (cfg_chan.index == REG_POLYNOMIAL);
  assign init_wr = cfg_chan.valid && (cfg_chan.index == REG_INITIAL_VALUE);
  assign cfg_chan.ready = 1'b1;

  assign advance = !out_valid_r || out_chan.ready;
  assign in_chan.ready = !build_busy_r && !poly_wr && (!s1_valid_r || advance);
  assign in_fire = in_chan.valid && in_chan.ready;

  assign out_chan.valid     = out_valid_r;
  assign out_chan.crc_value = crc_r;

  // next column: multiply by x modulo the polynomial
  assign work_nxt = work_r[CRC_W-1] ? ({work_r[CRC_W-2:0], 1'b0} ^ poly_r)
                                    : {work_r[CRC_W-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r       <= POLY_RESET;
      init_r       <= INIT_RESET;
      work_r       <= POLY_RESET;
      build_cnt_r  <= '0;
      build_busy_r <= 1'b1;
    end else begin
      if (init_wr) begin
        init_r <= cfg_chan.data;
      end
      if (poly_wr) begin
        poly_r       <= cfg_chan.data;
        work_r       <= cfg_chan.data;
        build_cnt_r  <= '0;
        build_busy_r <= 1'b1;
      end else if (build_busy_r) begin
        work_r      <= work_nxt;
        build_cnt_r <= build_cnt_r + col_idx_t'(1);
        if (build_cnt_r == COL_LAST) begin
          build_busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (build_busy_r && !poly_wr) begin
      col_r[build_cnt_r] <= work_r;
    end
  end

  // remainder update: high bytes reduced through the columns, low bytes shifted up
  always_comb begin
    rem_base = s1_sop_r ? ~init_r : rem_r;
    mix      = rem_base ^ s1_word_r;
    case (s1_cnt_r)
      3'd0: begin
        top_bits = '0;
        shifted  = rem_base;
      end
      3'd1: begin
        top_bits = {24'd0, mix[31:24]};
        shifted  = {rem_base[23:0], 8'd0};
      end
      3'd2: begin
        top_bits = {16'd0, mix[31:16]};
        shifted  = {rem_base[15:0], 16'd0};
      end
      3'd3: begin
        top_bits = {8'd0, mix[31:8]};
        shifted  = {rem_base[7:0], 24'd0};
      end
      default: begin
        // four bytes, counts above four saturate here
        top_bits = mix;
        shifted  = '0;
      end
    endcase
    folded = '0;
    for (int j = 0; j < CRC_W; j++) begin
      folded = folded ^ ({CRC_W{top_bits[j]}} & col_r[j]);
    end
    rem_nxt = shifted ^ folded;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      rem_r       <= CRC_ALL_ONES;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_valid_r && advance) begin
        out_valid_r <= 1'b1;
        rem_r       <= rem_nxt;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sop_r  <= in_chan.start_of_message;
      s1_word_r <= in_chan.data_word;
      s1_cnt_r  <= in_chan.byte_count;
    end
    if (s1_valid_r && advance) begin
      crc_r <= ~rem_nxt;
    end
  end

`ifndef SYNTHESIS
  a_poly_wr_rebuilds: assert property (@(posedge clk) disable iff (!rst_n)
    poly_wr |=> (build_busy_r && build_cnt_r == '0))
    else $error("polynomial write did not restart the column build");

  a_no_accept_in_build: assert property (@(posedge clk) disable iff (!rst_n)
    build_busy_r |-> !in_fire)
    else $error("item accepted while columns are being built");

  a_stage_moves_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && advance) |=> (out_valid_r && crc_r == ~rem_r))
    else $error("result register does not match updated remainder");

  a_stall_holds_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |=> $stable(rem_r))
    else $error("remainder changed while result stalled");
`endif

endmodule
